[hw/rtl/fitch_parsimony_tree_length_assert.svh]
// assertion macros used by the checker file
`ifndef FITCH_PARSIMONY_TREE_LENGTH_ASSERT_SVH
`define FITCH_PARSIMONY_TREE_LENGTH_ASSERT_SVH

// condition in one cycle implies consequence in the same cycle
`define FPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpt assertion failed");

// condition in one cycle implies consequence in the next cycle
`define FPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpt assertion failed");

`endif

[hw/rtl/fpt_pkg.sv]
// types, constants and helpers for the fitch parsimony length block
`timescale 1ns / 1ps
`default_nettype none
package fpt_pkg;

   localparam int MAX_BRANCHES_DEF = 256;
   localparam int MAX_WORDS_DEF    = 64;
   localparam int SETS_PER_WORD    = 16;
   localparam int CNT_W            = $clog2(SETS_PER_WORD + 1);
   localparam int LEN_W            = 19;
   localparam int CHG_W            = 18;
   localparam logic [LEN_W-1:0] LEN_SAT = '1;
   localparam logic [CHG_W-1:0] CHG_SAT = '1;

   localparam logic [1:0] OP_WRITE_LEAF   = 2'd0;
   localparam logic [1:0] OP_SET_CHILDREN = 2'd1;
   localparam logic [1:0] OP_EVALUATE     = 2'd2;

   localparam logic [1:0] CSR_LEAF_COUNT   = 2'd0;
   localparam logic [1:0] CSR_BRANCH_COUNT = 2'd1;
   localparam logic [1:0] CSR_WORD_COUNT   = 2'd2;

   localparam logic [8:0] LEAF_COUNT_RST   = 9'd2;
   localparam logic [8:0] BRANCH_COUNT_RST = 9'd3;
   localparam logic [6:0] WORD_COUNT_RST   = 7'd1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  branch_index;
      logic [7:0]  left_child;
      logic [7:0]  right_child;
      logic [5:0]  word_index;
      logic [63:0] state_word;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] tree_length;
      logic             zero_length_error;
   } rsp_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                                 input logic [CHG_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + (LEN_W+1)'(b);
      return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
   endfunction

   function automatic logic [CHG_W-1:0] sat_chg(input logic [CHG_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CHG_W:0] s;
      s = {1'b0, a} + (CHG_W+1)'(b);
      return s[CHG_W] ? CHG_SAT : s[CHG_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/fpt_merge.sv]
// one fitch merge over a word of nibble state sets
`timescale 1ns / 1ps
`default_nettype none
module fpt_merge import fpt_pkg::*; (
   input  wire logic [63:0]      x,
   input  wire logic [63:0]      y,
   output logic      [63:0]      z,
   output logic      [CNT_W-1:0] changes
);

   always_comb begin
      logic [3:0] a;
      logic [3:0] u;
      z = '0;
      changes = '0;
      for (int k = 0; k < SETS_PER_WORD; k++) begin
         a = x[4*k +: 4] & y[4*k +: 4];
         u = x[4*k +: 4] | y[4*k +: 4];
         if (a == 4'd0) begin
            z[4*k +: 4] = u;
            changes = changes + CNT_W'(1);
         end else begin
            z[4*k +: 4] = a;
         end
      end
   end

endmodule
`default_nettype wire

[hw/rtl/fitch_parsimony_tree_length.sv]
// fitch parsimony tree length: top level with state, link and count memories
//
// Load and link items (write leaf word, set children) keep busy low, so they
// may follow each other in every cycle. An evaluate item raises busy, sweeps
// the internal branches (S_SUM_RD, S_SUM_ADD) for the counts of clean ones,
// then runs merge passes: S_LINK_RD skips clean branches, S_LINK_CHK checks
// the children of dirty ones, and a branch that merges runs S_W_RD and
// S_W_MERGE per word and stores its count in S_BR_DONE. Passes repeat until
// one merges nothing. The root then reads its links in S_ROOT_LINK and
// S_ROOT_PREP, runs S_ROOT_RD, S_ROOT_M1 and S_ROOT_M2 per word and returns
// the item in S_FINISH. The two-read, one-write state-set memory sets these
// per-word steps. The result appears with rsp_valid for one cycle as busy
// falls; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module fitch_parsimony_tree_length import fpt_pkg::*; #(
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEF,
   parameter int MAX_WORDS    = MAX_WORDS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_wdata
);

   localparam int BW  = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
   localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CW  = ((BW + 1) > 9) ? (BW + 1) : 9;
   localparam int JW  = ($clog2(MAX_WORDS + 1) > 7) ? $clog2(MAX_WORDS + 1) : 7;
   localparam int DEPTH = MAX_BRANCHES * MAX_WORDS;
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM_RD, S_SUM_ADD, S_LINK_RD, S_LINK_CHK, S_W_RD, S_W_MERGE,
      S_BR_DONE, S_ROOT_LINK, S_ROOT_PREP, S_ROOT_RD, S_ROOT_M1, S_ROOT_M2,
      S_FINISH
   } state_type;

   state_type        state_ff;
   logic [8:0]       leaf_count_ff;
   logic [8:0]       branch_count_ff;
   logic [6:0]       word_count_ff;
   logic [CW-1:0]    i_ff;
   logic [JW-1:0]    j_ff;
   logic [7:0]       l_ff, r_ff;
   logic [7:0]       root_ff;
   logic [LEN_W-1:0] total_ff;
   logic [CHG_W-1:0] sum_ff;
   logic             progress_ff;
   logic [63:0]      m_ff;

   logic [MAX_BRANCHES-1:0] dirty_ff;
   logic [MAX_BRANCHES-1:0] link_ok_ff;

   // memories
   logic [63:0]      st_mem [DEPTH];
   logic [CHG_W-1:0] chg_mem [MAX_BRANCHES];
   logic [15:0]      link_mem [MAX_BRANCHES];

   logic [63:0]      rd_a_ff, rd_b_ff;
   logic             ok_a_ff, ok_b_ff;
   logic [CHG_W-1:0] chg_rd_ff;
   logic             chg_rd_ok_ff;
   logic [15:0]      link_rd_ff;
   logic             link_rd_ok_ff;

   logic [CW-1:0] nb, lc, ix, lx, rx, bx;
   logic [JW-1:0] nw;
   logic          accept;
   logic [AW-1:0] addr_a, addr_b, waddr;
   logic          ok_a, ok_b, st_we;
   logic [63:0]   st_wdata;
   logic [63:0]   mx, my, mz, rd_a_m, rd_b_m;
   logic [CNT_W-1:0] mcnt;
   logic [7:0]    link_l, link_r;
   logic          clean_l, clean_r;
   logic [CW-1:0] i_in;
   logic [JW-1:0] j_in;

   function automatic logic [AW-1:0] st_addr(input logic [BW-1:0] b,
                                             input logic [WW-1:0] w);
      return AW'(AW'(b) * AW'(MAX_WORDS) + AW'(w));
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign lc     = CW'(leaf_count_ff);
   assign nb     = (CW'(branch_count_ff) > CW'(MAX_BRANCHES)) ? CW'(MAX_BRANCHES)
                                                             : CW'(branch_count_ff);
   assign nw     = (JW'(word_count_ff) > JW'(MAX_WORDS)) ? JW'(MAX_WORDS)
                                                         : JW'(word_count_ff);
   assign ix     = CW'(req_data.branch_index);
   assign lx     = CW'(l_ff);
   assign rx     = CW'(r_ff);
   assign bx     = CW'(root_ff);
   assign i_in   = i_ff + CW'(1);
   assign j_in   = j_ff + JW'(1);

   assign link_l = link_rd_ok_ff ? link_rd_ff[15:8] : 8'd0;
   assign link_r = link_rd_ok_ff ? link_rd_ff[7:0]  : 8'd0;

   // a child that is a leaf, out of range or not dirty counts as clean
   always_comb begin
      logic [CW-1:0] cl, cr;
      cl = CW'(link_l);
      cr = CW'(link_r);
      clean_l = (cl < lc) || (cl >= CW'(MAX_BRANCHES)) || !dirty_ff[cl[BW-1:0]];
      clean_r = (cr < lc) || (cr >= CW'(MAX_BRANCHES)) || !dirty_ff[cr[BW-1:0]];
   end

   // read addresses of the state-set memory
   always_comb begin
      addr_a = st_addr(lx[BW-1:0], j_ff[WW-1:0]);
      addr_b = st_addr(rx[BW-1:0], j_ff[WW-1:0]);
      ok_a   = (lx < CW'(MAX_BRANCHES));
      ok_b   = (rx < CW'(MAX_BRANCHES));
      if (state_ff == S_ROOT_M1) begin
         addr_a = st_addr(bx[BW-1:0], j_ff[WW-1:0]);
         ok_a   = (bx < CW'(MAX_BRANCHES));
      end
   end

   assign rd_a_m = ok_a_ff ? rd_a_ff : 64'd0;
   assign rd_b_m = ok_b_ff ? rd_b_ff : 64'd0;
   assign mx     = (state_ff == S_ROOT_M2) ? m_ff   : rd_a_m;
   assign my     = (state_ff == S_ROOT_M2) ? rd_a_m : rd_b_m;

   fpt_merge u_merge (
      .x       (mx),
      .y       (my),
      .z       (mz),
      .changes (mcnt)
   );

   // write port of the state-set memory
   always_comb begin
      st_we    = 1'b0;
      waddr    = st_addr(i_ff[BW-1:0], j_ff[WW-1:0]);
      st_wdata = mz;
      if (state_ff == S_W_MERGE) begin
         st_we = 1'b1;
      end else if (accept && req_data.operation == OP_WRITE_LEAF) begin
         st_we    = (ix < CW'(MAX_BRANCHES)) &&
                    (JW'(req_data.word_index) < JW'(MAX_WORDS));
         waddr    = st_addr(ix[BW-1:0], WW'(req_data.word_index));
         st_wdata = req_data.state_word;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[waddr] <= st_wdata;
      end
      rd_a_ff <= st_mem[addr_a];
      rd_b_ff <= st_mem[addr_b];
      ok_a_ff <= ok_a;
      ok_b_ff <= ok_b;
   end

   // link memory: written by set children, read for a branch or the root
   always_ff @(posedge clock) begin
      logic [CW-1:0] la;
      la = (state_ff == S_ROOT_LINK) ? bx : i_ff;
      if (accept && req_data.operation == OP_SET_CHILDREN &&
          ix < CW'(MAX_BRANCHES)) begin
         link_mem[ix[BW-1:0]] <= {req_data.left_child, req_data.right_child};
      end
      link_rd_ff    <= link_mem[la[BW-1:0]];
      link_rd_ok_ff <= link_ok_ff[la[BW-1:0]] && (la < CW'(MAX_BRANCHES));
   end

   // change count memory: a clean branch that was ever linked has been merged
   always_ff @(posedge clock) begin
      if (state_ff == S_BR_DONE) begin
         chg_mem[i_ff[BW-1:0]] <= sum_ff;
      end
      chg_rd_ff    <= chg_mem[i_ff[BW-1:0]];
      chg_rd_ok_ff <= link_ok_ff[i_ff[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         leaf_count_ff   <= LEAF_COUNT_RST;
         branch_count_ff <= BRANCH_COUNT_RST;
         word_count_ff   <= WORD_COUNT_RST;
         dirty_ff        <= '0;
         link_ok_ff      <= '0;
         rsp_valid       <= 1'b0;
         progress_ff     <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_LEAF_COUNT:   leaf_count_ff   <= csr_wdata;
               CSR_BRANCH_COUNT: branch_count_ff <= csr_wdata;
               CSR_WORD_COUNT:   word_count_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_data.operation)
                     OP_SET_CHILDREN: begin
                        if (ix < CW'(MAX_BRANCHES)) begin
                           dirty_ff[ix[BW-1:0]]   <= 1'b1;
                           link_ok_ff[ix[BW-1:0]] <= 1'b1;
                        end
                     end
                     OP_EVALUATE: begin
                        root_ff  <= req_data.branch_index;
                        total_ff <= '0;
                        i_ff     <= lc;
                        state_ff <= S_SUM_RD;
                     end
                     default: ;
                  endcase
               end
            end
            // gather counts of clean branches, skip dirty ones
            S_SUM_RD: begin
               if (i_ff >= nb) begin
                  i_ff        <= lc;
                  progress_ff <= 1'b0;
                  state_ff    <= S_LINK_RD;
               end else begin
                  state_ff <= S_SUM_ADD;
               end
            end
            S_SUM_ADD: begin
               if (!dirty_ff[i_ff[BW-1:0]] && chg_rd_ok_ff) begin
                  total_ff <= sat_len(total_ff, chg_rd_ff);
               end
               i_ff     <= i_in;
               state_ff <= S_SUM_RD;
            end
            // merge pass
            S_LINK_RD: begin
               if (i_ff >= nb) begin
                  if (progress_ff) begin
                     i_ff        <= lc;
                     progress_ff <= 1'b0;
                  end else begin
                     state_ff <= S_ROOT_LINK;
                  end
               end else if (!dirty_ff[i_ff[BW-1:0]]) begin
                  i_ff <= i_in;
               end else begin
                  state_ff <= S_LINK_CHK;
               end
            end
            S_LINK_CHK: begin
               if (clean_l && clean_r) begin
                  l_ff     <= link_l;
                  r_ff     <= link_r;
                  j_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= (nw == JW'(0)) ? S_BR_DONE : S_W_RD;
               end else begin
                  i_ff     <= i_in;
                  state_ff <= S_LINK_RD;
               end
            end
            S_W_RD: begin
               state_ff <= S_W_MERGE;
            end
            S_W_MERGE: begin
               sum_ff   <= sat_chg(sum_ff, mcnt);
               j_ff     <= j_in;
               state_ff <= (j_in == nw) ? S_BR_DONE : S_W_RD;
            end
            S_BR_DONE: begin
               dirty_ff[i_ff[BW-1:0]]  <= 1'b0;
               total_ff    <= sat_len(total_ff, sum_ff);
               progress_ff <= 1'b1;
               i_ff        <= i_in;
               state_ff    <= S_LINK_RD;
            end
            // root: merge the children, then with the root's own set
            S_ROOT_LINK: begin
               state_ff <= S_ROOT_PREP;
            end
            S_ROOT_PREP: begin
               l_ff     <= link_l;
               r_ff     <= link_r;
               j_ff     <= '0;
               state_ff <= (nw == JW'(0)) ? S_FINISH : S_ROOT_RD;
            end
            S_ROOT_RD: begin
               state_ff <= S_ROOT_M1;
            end
            S_ROOT_M1: begin
               m_ff     <= mz;
               total_ff <= sat_len(total_ff, CHG_W'(mcnt));
               state_ff <= S_ROOT_M2;
            end
            S_ROOT_M2: begin
               total_ff <= sat_len(total_ff, CHG_W'(mcnt));
               j_ff     <= j_in;
               state_ff <= (j_in == nw) ? S_FINISH : S_ROOT_RD;
            end
            S_FINISH: begin
               rsp_valid                  <= 1'b1;
               rsp_data.tree_length       <= total_ff;
               rsp_data.zero_length_error <= (total_ff == '0);
               state_ff                   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[hw/rtl/fpt_checker.sv]
// port-level checks of the fitch parsimony length block and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "fitch_parsimony_tree_length_assert.svh"
module fpt_checker import fpt_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire req_type    req_data,
   input wire logic       rsp_valid,
   input wire rsp_type    rsp_data,
   input wire logic       csr_we,
   input wire logic [1:0] csr_index,
   input wire logic [8:0] csr_wdata
);

   logic eval_acc, other_acc;

   assign eval_acc  = start && !busy && (req_data.operation == OP_EVALUATE);
   assign other_acc = start && !busy && (req_data.operation != OP_EVALUATE);

   `FPT_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid, rsp_data.zero_length_error == (rsp_data.tree_length == '0))
   `FPT_ASSERT_NEXT(a_eval_busy, clock, reset, eval_acc, busy)
   `FPT_ASSERT_NEXT(a_load_quiet, clock, reset, other_acc, !busy && !rsp_valid)
   `FPT_ASSERT_NOW(a_rsp_at_end, clock, reset, 1'b1, rsp_valid == $fell(busy))

endmodule

bind fitch_parsimony_tree_length fpt_checker u_fpt_checker (.*);
`default_nettype wire

[tb/sv/tb_fitch_parsimony_tree_length.sv]
// testbench for the fitch parsimony tree length block: directed and random trees
`timescale 1ns / 1ps
module tb_fitch_parsimony_tree_length;
   import fpt_pkg::*;

   localparam logic [1:0] OP_IGNORED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         LENGTH_MAX  = 524287;
   localparam int         CHANGES_MAX = 262143;
   localparam int         STALL_LIMIT = 1500000;
   localparam int         RANDOM_ITEMS = 270;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [1:0] csr_index;
   logic [8:0] csr_wdata;

   fitch_parsimony_tree_length u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // own copy of the tree tables
   bit [63:0] set_words [0:16383];
   bit [63:0] word_known [256];
   int        branch_chg [256];
   bit [7:0]  left_of [256];
   bit [7:0]  right_of [256];
   bit        pending [256];
   int        leaf_cnt = 2;
   int        branch_cnt = 3;
   int        word_cnt = 1;

   rsp_type expected_lengths [$];
   rsp_type want;
   int      errors = 0;
   int      items_sent = 0;
   int      lengths_checked = 0;
   int      reg_writes = 0;
   int      idle_pct = 35;
   int      stall_cycles = 0;

   function automatic int add_capped(input int a, input int b, input int lim);
      return (a + b > lim) ? lim : a + b;
   endfunction

   function automatic bit [63:0] merge_sets(input bit [63:0] x, input bit [63:0] y,
                                            output int changes);
      bit [63:0] r;
      bit [3:0]  a;
      changes = 0;
      for (int k = 0; k < 16; k++) begin
         a = x[4*k +: 4] & y[4*k +: 4];
         if (a == 4'd0) begin
            r[4*k +: 4] = x[4*k +: 4] | y[4*k +: 4];
            changes++;
         end else begin
            r[4*k +: 4] = a;
         end
      end
      return r;
   endfunction

   function automatic int used_branches();
      return (branch_cnt > 256) ? 256 : branch_cnt;
   endfunction

   function automatic int used_words();
      return (word_cnt > 64) ? 64 : word_cnt;
   endfunction

   function automatic rsp_type tree_length_of(input int root);
      rsp_type   res;
      int        nb, nw, total, sum, c, l, r;
      bit        progress;
      bit [63:0] m;
      nb = used_branches();
      nw = used_words();
      total = 0;
      for (int i = leaf_cnt; i < nb; i++) begin
         if (pending[i]) branch_chg[i] = 0;
         else total = add_capped(total, branch_chg[i], LENGTH_MAX);
      end
      do begin
         progress = 1'b0;
         for (int i = leaf_cnt; i < nb; i++) begin
            if (!pending[i]) continue;
            l = left_of[i];
            r = right_of[i];
            if (!(l < leaf_cnt || !pending[l]) || !(r < leaf_cnt || !pending[r])) continue;
            sum = 0;
            for (int j = 0; j < nw; j++) begin
               m = merge_sets(set_words[l*64+j], set_words[r*64+j], c);
               set_words[i*64+j] = m;
               word_known[i][j] = 1'b1;
               sum = add_capped(sum, c, CHANGES_MAX);
            end
            branch_chg[i] = sum;
            pending[i] = 1'b0;
            total = add_capped(total, sum, LENGTH_MAX);
            progress = 1'b1;
         end
      end while (progress);
      l = left_of[root];
      r = right_of[root];
      for (int j = 0; j < nw; j++) begin
         m = merge_sets(set_words[l*64+j], set_words[r*64+j], c);
         total = add_capped(total, c, LENGTH_MAX);
         m = merge_sets(m, set_words[root*64+j], c);
         total = add_capped(total, c, LENGTH_MAX);
      end
      res.tree_length = total[LEN_W-1:0];
      res.zero_length_error = (total == 0);
      return res;
   endfunction

   // walks the evaluation without changing anything and finds a word it would
   // read before anyone wrote it
   function automatic bit find_unwritten(input int root, output int gb, output int gj);
      bit [63:0] known [256];
      bit        dirt [256];
      int        nb, nw, l, r;
      bit        progress;
      known = word_known;
      dirt = pending;
      nb = used_branches();
      nw = used_words();
      gb = 0;
      gj = 0;
      do begin
         progress = 1'b0;
         for (int i = leaf_cnt; i < nb; i++) begin
            if (!dirt[i]) continue;
            l = left_of[i];
            r = right_of[i];
            if (!(l < leaf_cnt || !dirt[l]) || !(r < leaf_cnt || !dirt[r])) continue;
            for (int j = 0; j < nw; j++) begin
               if (!known[l][j]) begin gb = l; gj = j; return 1'b1; end
               if (!known[r][j]) begin gb = r; gj = j; return 1'b1; end
               known[i][j] = 1'b1;
            end
            dirt[i] = 1'b0;
            progress = 1'b1;
         end
      end while (progress);
      for (int j = 0; j < nw; j++) begin
         if (!known[left_of[root]][j]) begin gb = left_of[root]; gj = j; return 1'b1; end
         if (!known[right_of[root]][j]) begin gb = right_of[root]; gj = j; return 1'b1; end
         if (!known[root][j]) begin gb = root; gj = j; return 1'b1; end
      end
      return 1'b0;
   endfunction

   function automatic void apply_item(input req_type it);
      int b;
      b = it.branch_index;
      case (it.operation)
         OP_WRITE_LEAF: begin
            set_words[b*64 + it.word_index] = it.state_word;
            word_known[b][it.word_index] = 1'b1;
         end
         OP_SET_CHILDREN: begin
            left_of[b] = it.left_child;
            right_of[b] = it.right_child;
            pending[b] = 1'b1;
         end
         OP_EVALUATE: expected_lengths.push_back(tree_length_of(b));
         default: ;
      endcase
   endfunction

   // mostly single nucleotides, with ambiguous, full and empty sets mixed in
   function automatic bit [63:0] random_sets();
      bit [63:0] w;
      for (int k = 0; k < 16; k++) begin
         case ($urandom_range(9))
            7: w[4*k +: 4] = 4'($urandom_range(15));
            8: w[4*k +: 4] = 4'hF;
            9: w[4*k +: 4] = 4'h0;
            default: w[4*k +: 4] = 4'd1 << $urandom_range(3);
         endcase
      end
      return w;
   endfunction

   task automatic send_item(input req_type it);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start = 1'b1;
      req_data = it;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_item(it);
      items_sent++;
   endtask

   task automatic send_write(input int b, input int w, input bit [63:0] d);
      req_type it;
      it = '0;
      it.operation = OP_WRITE_LEAF;
      it.branch_index = 8'(b);
      it.word_index = 6'(w);
      it.state_word = d;
      it.left_child = 8'($urandom_range(255));
      it.right_child = 8'($urandom_range(255));
      send_item(it);
   endtask

   task automatic send_link(input int b, input int l, input int r);
      req_type it;
      it = '0;
      it.operation = OP_SET_CHILDREN;
      it.branch_index = 8'(b);
      it.left_child = 8'(l);
      it.right_child = 8'(r);
      it.word_index = 6'($urandom_range(63));
      it.state_word = {$urandom, $urandom};
      send_item(it);
   endtask

   task automatic send_evaluate(input int root);
      req_type it;
      int gb, gj;
      while (find_unwritten(root, gb, gj)) send_write(gb, gj, random_sets());
      it = '0;
      it.operation = OP_EVALUATE;
      it.branch_index = 8'(root);
      it.word_index = 6'($urandom_range(63));
      send_item(it);
   endtask

   // block idle: nothing owed and any last load or link finished
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_lengths.size() != 0 || busy) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input int value);
      drain();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = 9'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_LEAF_COUNT:   leaf_cnt = value & 'h1FF;
         CSR_BRANCH_COUNT: branch_cnt = value & 'h1FF;
         CSR_WORD_COUNT:   word_cnt = value & 'h7F;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic set_shape(input int leaves, input int branches, input int words);
      write_register(CSR_LEAF_COUNT, leaves);
      write_register(CSR_BRANCH_COUNT, branches);
      write_register(CSR_WORD_COUNT, words);
   endtask

   // loads leaves, links a random tree bottom up, evaluates, then edits and
   // evaluates again
   task automatic run_tree(input int noise_pct);
      int nb, nw, lc, root, b;
      nb = used_branches();
      nw = used_words();
      lc = (leaf_cnt > 256) ? 256 : leaf_cnt;
      for (int b0 = 0; b0 < lc; b0++)
         for (int j = 0; j < nw; j++) send_write(b0, j, random_sets());
      for (int i = leaf_cnt; i < nb; i++) begin
         send_link(i, $urandom_range(i - 1), $urandom_range(i - 1));
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: send_link($urandom_range(255), $urandom_range(255), $urandom_range(255));
               1: send_write($urandom_range(255), $urandom_range(63), {$urandom, $urandom});
               default: begin
                  send_item('{OP_IGNORED, 8'($urandom), 8'($urandom), 8'($urandom),
                              6'($urandom), {$urandom, $urandom}});
               end
            endcase
         end
      end
      root = (nb > leaf_cnt) ? nb - 1 : $urandom_range(255);
      send_evaluate(root);
      repeat ($urandom_range(1, 2)) begin
         if (lc > 0) send_write($urandom_range(lc - 1), $urandom_range(nw > 0 ? nw - 1 : 0),
                                random_sets());
         if (nb > leaf_cnt) begin
            b = $urandom_range(nb - 1, leaf_cnt);
            send_link(b, $urandom_range(b - 1), $urandom_range(b - 1));
         end
         send_evaluate($urandom_range(99) < 80 ? root : $urandom_range(255));
      end
   endtask

   task automatic test_default_tree();
      send_write(0, 0, 64'h1111_1111_1111_1111);
      send_write(1, 0, 64'h2222_2222_2222_2222);
      send_link(2, 0, 1);
      send_evaluate(2);
      send_write(0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_write(1, 0, 64'h0000_0000_0000_0000);
      send_link(2, 1, 0);
      send_evaluate(2);
      send_evaluate(0);
   endtask

   task automatic test_special_cases();
      req_type it;
      // ignored operation with every field at its top
      it = '1;
      it.operation = OP_IGNORED;
      send_item(it);
      send_write(255, 63, 64'hFFFF_FFFF_FFFF_FFFF);
      send_link(255, 255, 255);
      // a branch linked to itself never becomes clean
      send_link(2, 2, 2);
      send_evaluate(2);
      send_evaluate(255);
      send_link(2, 0, 1);
      send_evaluate(2);
      // two branches feeding each other stay dirty
      drain();
      set_shape(2, 5, 1);
      send_link(3, 4, 0);
      send_link(4, 3, 1);
      send_link(2, 0, 1);
      send_evaluate(2);
      send_evaluate(4);
   endtask

   task automatic test_register_extremes();
      set_shape(2, 3, 0);          // no words in use
      send_evaluate(2);
      write_register(CSR_UNUSED, 511);
      set_shape(256, 511, 1);      // all leaves, branch count over the cap
      send_evaluate(255);
      set_shape(4, 256, 2);
      run_tree(5);
      set_shape(511, 256, 127);    // leaf count over the cap, word count over the cap
      send_link(0, 0, 0);
      send_evaluate(0);
      set_shape(2, 3, 1);
      run_tree(0);
   endtask

   task automatic test_random_trees();
      int first;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         if (items_sent - first < RANDOM_ITEMS / 3) idle_pct = 35;
         else if (items_sent - first < 2 * RANDOM_ITEMS / 3) idle_pct = 85;
         else idle_pct = 0;
         if ($urandom_range(99) < 30) drain();
         if ($urandom_range(99) < 60) begin
            leaf_cnt = $urandom_range(2, 8);
            set_shape(leaf_cnt, leaf_cnt + $urandom_range(1, 8), $urandom_range(1, 4));
         end
         run_tree(15);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_lengths.size() == 0) begin
            $error("tree_length: none expected, actual %0d", rsp_data.tree_length);
            errors++;
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_data.tree_length !== want.tree_length) begin
               $error("tree_length: expected %0d, actual %0d",
                      want.tree_length, rsp_data.tree_length);
               errors++;
            end
            if (rsp_data.zero_length_error !== want.zero_length_error) begin
               $error("zero_length_error: expected %0d, actual %0d",
                      want.zero_length_error, rsp_data.zero_length_error);
               errors++;
            end
            lengths_checked++;
         end
      end
   end

   // stall guard: counts cycles with no item taken and no length returned
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL fitch_parsimony_tree_length");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_LEAF_COUNT;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_tree();
      test_special_cases();
      test_register_extremes();
      test_random_trees();
      drain();
      repeat (20) @(negedge clock);
      $display("run covered %0d items, %0d tree lengths checked, %0d register writes",
               items_sent, lengths_checked, reg_writes);
      $display("trees were loaded, relinked and evaluated under three sender idle rates");
      if (errors == 0 && expected_lengths.size() == 0) begin
         $display("PASS fitch_parsimony_tree_length");
      end else begin
         $display("FAIL fitch_parsimony_tree_length");
      end
      $finish;
   end
endmodule
